// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the saturation helper of the complex arithmetic unit
// no dependencies

package cau_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QBITS     = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic        ov;
        logic [15:0] val;
    } sat_t;

    // word handed from cell to cell
    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic        ov;
        logic [15:0] res_re;
        logic [15:0] res_im;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [31:0] den;
        logic [31:0] rem_re;
        logic [31:0] rem_im;
        logic [15:0] lo_re;
        logic [15:0] lo_im;
        logic [15:0] q_re;
        logic [15:0] q_im;
    } cell_t;

    // clamp a sign and magnitude to signed 16 bits
    function automatic sat_t sat_mag(input logic [32:0] m, input logic neg);
        sat_t r;
        r.ov  = 1'b0;
        r.val = 16'h0000;
        if (neg) begin
            if (m > 33'd32768) begin
                r.ov  = 1'b1;
                r.val = 16'h8000;
            end else begin
                r.val = ~m[15:0] + 16'd1;
            end
        end else begin
            if (m > 33'd32767) begin
                r.ov  = 1'b1;
                r.val = 16'h7fff;
            end else begin
                r.val = m[15:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
`timescale 1ns / 1ps
// front end: products, sums and preparation of the divider word, three stages
// depends on cau_pkg

module cau_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  cau_pkg::op_t        op,
    input  logic signed [15:0]  a_re,
    input  logic signed [15:0]  a_im,
    input  logic signed [15:0]  b_re,
    input  logic signed [15:0]  b_im,
    output logic                out_valid,
    output cau_pkg::cell_t      out_cell
);

    // stage 1
    logic               v1_reg;
    cau_pkg::op_t       op1_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_br_reg, p_bi_reg;
    logic signed [16:0] s_re_reg, s_im_reg;

    // stage 2
    logic               v2_reg;
    cau_pkg::op_t       op2_reg;
    logic signed [32:0] x_re_reg, x_im_reg;
    logic [31:0]        den_reg;
    logic signed [32:0] x_re_next, x_im_next;
    logic [31:0]        den_next;

    // stage 3
    logic               v3_reg;
    cau_pkg::cell_t     cell_reg;
    cau_pkg::cell_t     cell_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= op;
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
            p_br_reg <= b_re * b_re;
            p_bi_reg <= b_im * b_im;
            if (op == cau_pkg::OP_SUB) begin
                s_re_reg <= 17'(a_re) - 17'(b_re);
                s_im_reg <= 17'(a_im) - 17'(b_im);
            end else begin
                s_re_reg <= 17'(a_re) + 17'(b_re);
                s_im_reg <= 17'(a_im) + 17'(b_im);
            end
            op2_reg  <= op1_reg;
            x_re_reg <= x_re_next;
            x_im_reg <= x_im_next;
            den_reg  <= den_next;
            cell_reg <= cell_next;
        end
    end

    always_comb begin
        den_next = 32'(p_br_reg) + 32'(p_bi_reg);
        case (op1_reg)
            cau_pkg::OP_MUL: begin
                x_re_next = 33'(p_rr_reg) - 33'(p_ii_reg);
                x_im_next = 33'(p_ri_reg) + 33'(p_ir_reg);
            end
            cau_pkg::OP_DIV: begin
                x_re_next = 33'(p_rr_reg) + 33'(p_ii_reg);
                x_im_next = 33'(p_ir_reg) - 33'(p_ri_reg);
            end
            default: begin
                x_re_next = 33'(s_re_reg);
                x_im_next = 33'(s_im_reg);
            end
        endcase
    end

    logic [32:0]   m_re, m_im;
    logic [47:0]   n_re, n_im, den_sh;
    cau_pkg::sat_t sr, si;

    always_comb begin
        m_re   = x_re_reg[32] ? 33'(-x_re_reg) : 33'(x_re_reg);
        m_im   = x_im_reg[32] ? 33'(-x_im_reg) : 33'(x_im_reg);
        n_re   = {15'd0, m_re} << cau_pkg::FRAC_BITS;
        n_im   = {15'd0, m_im} << cau_pkg::FRAC_BITS;
        den_sh = {16'd0, den_reg} << cau_pkg::QBITS;
        if (op2_reg == cau_pkg::OP_MUL) begin
            sr = cau_pkg::sat_mag(m_re >> cau_pkg::FRAC_BITS, x_re_reg[32]);
            si = cau_pkg::sat_mag(m_im >> cau_pkg::FRAC_BITS, x_im_reg[32]);
        end else begin
            sr = cau_pkg::sat_mag(m_re, x_re_reg[32]);
            si = cau_pkg::sat_mag(m_im, x_im_reg[32]);
        end
        cell_next.is_div = (op2_reg == cau_pkg::OP_DIV);
        cell_next.dz     = (op2_reg == cau_pkg::OP_DIV) && (den_reg == 32'd0);
        cell_next.ov     = sr.ov | si.ov;
        cell_next.res_re = sr.val;
        cell_next.res_im = si.val;
        cell_next.neg_re = x_re_reg[32];
        cell_next.neg_im = x_im_reg[32];
        cell_next.big_re = n_re >= den_sh;
        cell_next.big_im = n_im >= den_sh;
        cell_next.den    = den_reg;
        cell_next.rem_re = n_re[47:16];
        cell_next.rem_im = n_im[47:16];
        cell_next.lo_re  = n_re[15:0];
        cell_next.lo_im  = n_im[15:0];
        cell_next.q_re   = 16'd0;
        cell_next.q_im   = 16'd0;
    end

    assign out_valid = v3_reg;
    assign out_cell  = cell_reg;

endmodule

// ===== hw/rtl/cau_div_cell.sv =====
`timescale 1ns / 1ps
// one cell of the divider row: one quotient bit for each part per cell
// depends on cau_pkg

module cau_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cau_pkg::cell_t in_cell,
    output logic           out_valid,
    output cau_pkg::cell_t out_cell
);

    logic           valid_reg;
    cau_pkg::cell_t cell_reg;
    cau_pkg::cell_t cell_next;
    logic [32:0]    t_re, t_im, d;
    logic           ge_re, ge_im;

    always_comb begin
        d         = {1'b0, in_cell.den};
        t_re      = {in_cell.rem_re, in_cell.lo_re[15]};
        t_im      = {in_cell.rem_im, in_cell.lo_im[15]};
        ge_re     = t_re >= d;
        ge_im     = t_im >= d;
        cell_next = in_cell;
        cell_next.rem_re = ge_re ? 32'(t_re - d) : t_re[31:0];
        cell_next.rem_im = ge_im ? 32'(t_im - d) : t_im[31:0];
        cell_next.lo_re  = {in_cell.lo_re[14:0], 1'b0};
        cell_next.lo_im  = {in_cell.lo_im[14:0], 1'b0};
        cell_next.q_re   = {in_cell.q_re[14:0], ge_re};
        cell_next.q_im   = {in_cell.q_im[14:0], ge_im};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ===== hw/rtl/complex_arith_unit.sv =====
`timescale 1ns / 1ps
// top level of the complex arithmetic unit: front end, divider cell row, output register
// depends on cau_pkg, cau_front, cau_div_cell
//
// usage:
//   s_ channel carries one operation per word: s_tuser holds the operation
//   (add, subtract, multiply, divide) and s_tdata the operands a_re, a_im,
//   b_re, b_im in signed Q8.8. m_ channel returns one word per operation
//   with res_re, res_im (Q8.8, saturated), div_zero and overflow.
//   every operation, whatever its kind, takes the same path: three front
//   stages (products, sums, prep), a row of 16 divider cells each settling
//   one quotient bit, and an output register, so results leave in order.
//   throughput is one word per cycle while the receiver takes results;
//   the pipeline holds up to 20 words.
//   the whole pipeline advances whenever the output register is empty or
//   is being taken; while the receiver stalls with a result waiting, the
//   pipeline holds and s_tready drops.
//   aresetn (synchronous, active low) empties the pipeline; no state is kept
//   between operations.

module complex_arith_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // res_re[15:0], res_im[31:16], div_zero[32], overflow[33]
);

    localparam int NCELLS = cau_pkg::QBITS;

    logic           en;
    logic           out_valid_reg;
    logic [39:0]    out_data_reg;
    logic           chain_valid [NCELLS+1];
    cau_pkg::cell_t chain_cell  [NCELLS+1];

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .op        (cau_pkg::op_t'(s_tuser)),
        .a_re      (s_tdata[15:0]),
        .a_im      (s_tdata[31:16]),
        .b_re      (s_tdata[47:32]),
        .b_im      (s_tdata[63:48]),
        .out_valid (chain_valid[0]),
        .out_cell  (chain_cell[0])
    );

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        cau_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    cau_pkg::cell_t fc;
    cau_pkg::sat_t  qr, qi;
    logic [39:0]    out_data_next;

    always_comb begin
        fc = chain_cell[NCELLS];
        qr = cau_pkg::sat_mag(fc.big_re ? 33'h1_0000_0000 : {17'd0, fc.q_re}, fc.neg_re);
        qi = cau_pkg::sat_mag(fc.big_im ? 33'h1_0000_0000 : {17'd0, fc.q_im}, fc.neg_im);
        if (fc.is_div) begin
            if (fc.dz) begin
                out_data_next = {6'd0, 1'b0, 1'b1, 16'd0, 16'd0};
            end else begin
                out_data_next = {6'd0, qr.ov | qi.ov, 1'b0, qi.val, qr.val};
            end
        end else begin
            out_data_next = {6'd0, fc.ov, 1'b0, fc.res_im, fc.res_re};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= chain_valid[NCELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
